>>> rtl/core/crbm_pkg.sv
package crbm_pkg;

  localparam int IMAGE_SEGMENTS_DEF = 16;
  localparam int SEGMENT_BYTES      = 16384;
  localparam int SEG_OFS_W          = 14;
  localparam int SEG_W              = 4;
  localparam int ADDR_W             = SEG_W + SEG_OFS_W;
  localparam int SEG_SUM_W          = 6;

  localparam logic [15:0] WINDOW_BASE = 16'h4000;
  localparam logic [15:0] WINDOW_TOP  = 16'hC000;

  localparam logic [15:0] SEL_LO      = 16'h6000;
  localparam logic [15:0] SEL_HI      = 16'h8000;
  localparam logic [15:0] A16_SEL_HI  = 16'h7800;
  localparam logic [15:0] A16_GAP     = 16'h0800;
  localparam logic [15:0] SCC_SEL_LO  = 16'h5000;
  localparam logic [15:0] K8_SEL_HI   = 16'hC000;
  localparam logic [15:0] SCC_MASK    = 16'h1800;
  localparam logic [15:0] SCC_MATCH   = 16'h1000;

  localparam logic [2:0] KIND_PLAIN  = 3'd0;
  localparam logic [2:0] KIND_ASCII8 = 3'd1;
  localparam logic [2:0] KIND_ASCII16 = 3'd2;
  localparam logic [2:0] KIND_K8     = 3'd3;
  localparam logic [2:0] KIND_K8_SCC = 3'd4;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [1:0] REG_KIND    = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_BASE    = 2'd2;
  localparam logic [1:0] REG_ENABLE  = 2'd3;

  typedef struct packed {
    logic        start;
    logic [2:0]  kind;
    logic [5:0]  count;
    logic [15:0] addr;
    logic [7:0]  data;
  } bank_req_t;

endpackage

>>> rtl/core/crbm_ram.sv
module crbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/crbm_bank.sv
module crbm_bank
  import crbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  bank_req_t req,
  input  logic [1:0] rd_slot,
  output logic [4:0] rd_bank,
  output logic       done
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t      state;
  logic [4:0]  banks [4];
  logic        hit;
  logic [1:0]  sel_slot;
  logic [1:0]  slot;
  logic [5:0]  divisor;
  logic [5:0]  div_next;
  logic [7:0]  dividend;
  logic [5:0]  rem;
  logic [6:0]  trial;
  logic [5:0]  rem_next;
  logic [2:0]  step;

  assign rd_bank = banks[rd_slot];

  always_comb begin
    hit      = 1'b0;
    sel_slot = 2'd0;
    unique case (req.kind)
      KIND_ASCII8: begin
        if (req.addr >= SEL_LO && req.addr < SEL_HI) begin
          hit      = 1'b1;
          sel_slot = req.addr[12:11];
        end
      end
      KIND_ASCII16: begin
        if (req.addr >= SEL_LO && req.addr < A16_SEL_HI &&
            (req.addr & A16_GAP) == 16'h0000) begin
          hit      = 1'b1;
          sel_slot = {1'b0, req.addr[12]};
        end
      end
      KIND_K8: begin
        if (req.addr >= SEL_LO && req.addr < K8_SEL_HI) begin
          hit      = 1'b1;
          sel_slot = req.addr[14:13] - 2'd2;
        end
      end
      KIND_K8_SCC: begin
        if (req.addr >= SCC_SEL_LO && req.addr < K8_SEL_HI &&
            (req.addr & SCC_MASK) == SCC_MATCH) begin
          hit      = 1'b1;
          sel_slot = req.addr[14:13] - 2'd2;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (req.count == 6'd0) begin
      div_next = 6'd1;
    end else if (req.count > 6'd32) begin
      div_next = 6'd32;
    end else begin
      div_next = req.count;
    end
  end

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial = {rem, dividend[7]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = 6'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      step  <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        banks[i] <= 5'(i);
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            if (hit) begin
              state    <= S_RUN;
              slot     <= sel_slot;
              divisor  <= div_next;
              dividend <= req.data;
              rem      <= 6'd0;
              step     <= 3'd0;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_RUN: begin
          rem      <= rem_next;
          dividend <= {dividend[6:0], 1'b0};
          step     <= step + 3'd1;
          if (step == 3'd7) begin
            banks[slot] <= rem_next[4:0];
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/cartridge_rom_bank_mapper.sv
// Channel   Direction  Payload
// s_*       in         tuser: mode; tdata: bus_address, image_address, data_byte
// m_*       out        tdata: read_data, mapped_address
// apb       in/out     mapper_kind, bank_count, base_segment, rom_enabled
//
// One word at a time. Load: image RAM write. Bus read: bank lookup, image
// RAM read, output register; it stalls while the output word is held by m_tready.
// Bus write that hits a select address: waits on the 8-step remainder unit;
// other bus writes and dropped words do not run it.
// Reset restores config registers and banks 0..3; image RAM has no clearing pass.
// A finished read word waits in the output register while the next word is taken.
module cartridge_rom_bank_mapper
  import crbm_pkg::*;
#(
  parameter int IMAGE_SEGMENTS = IMAGE_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // bus_address, image_address, data_byte, zero pad
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_data, mapped_address, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MEM_DEPTH = IMAGE_SEGMENTS * SEGMENT_BYTES;
  localparam int RAM_AW    = $clog2(MEM_DEPTH);
  localparam int TAB_DEPTH = 2 ** SEG_SUM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_BANK
  } state_t;

  state_t      state;
  logic [2:0]  mapper_kind;
  logic [5:0]  bank_count;
  logic [3:0]  base_segment;
  logic        rom_enabled;

  logic [1:0]  mode;
  logic [15:0] bus_address;
  logic [17:0] image_address;
  logic [7:0]  data_byte;

  logic [ADDR_W-1:0] mapped_address;
  logic [ADDR_W-1:0] hold_addr;
  logic [7:0]        read_data;

  logic [SEG_W-1:0] seg_tab [TAB_DEPTH];
  logic [14:0]      win_ofs;
  logic             in_window;
  logic [1:0]       rd_slot;
  logic [4:0]       rd_bank;
  logic [SEG_SUM_W-1:0] seg_sum;
  logic [SEG_OFS_W-1:0] seg_ofs;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    ld_addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [7:0]           ram_rdata;
  logic                 bank_done;
  bank_req_t            bank_req;
  logic                 cfg_wr;

  for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_seg_tab
    assign seg_tab[i] = SEG_W'(i % IMAGE_SEGMENTS);
  end

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign m_tdata  = {6'd0, mapped_address, read_data};

  always_comb begin
    unique case (paddr[3:2])
      REG_KIND:   prdata = {29'd0, mapper_kind};
      REG_COUNT:  prdata = {26'd0, bank_count};
      REG_BASE:   prdata = {28'd0, base_segment};
      REG_ENABLE: prdata = {31'd0, rom_enabled};
      default:    prdata = 32'd0;
    endcase
  end

  assign in_window = (bus_address >= WINDOW_BASE) && (bus_address < WINDOW_TOP);
  assign win_ofs   = 15'(bus_address - WINDOW_BASE);

  always_comb begin
    if (mapper_kind == KIND_ASCII16) begin
      rd_slot = {1'b0, win_ofs[14]};
      seg_sum = SEG_SUM_W'({2'b00, base_segment} + {1'b0, rd_bank});
      seg_ofs = win_ofs[13:0];
    end else begin
      rd_slot = win_ofs[14:13];
      seg_sum = SEG_SUM_W'({2'b00, base_segment} + {2'b00, rd_bank[4:1]});
      seg_ofs = {rd_bank[0], win_ofs[12:0]};
    end
  end

  assign rd_addr = {seg_tab[seg_sum], seg_ofs};
  assign ld_addr = {seg_tab[{2'b00, image_address[17:14]}], image_address[13:0]};

  assign ram_we = (state == ST_EXEC) && (mode == MODE_LOAD);
  assign ram_re = (state == ST_EXEC) && (mode == MODE_READ) && rom_enabled && in_window;

  assign bank_req.start = (state == ST_EXEC) && (mode == MODE_WRITE) && rom_enabled;
  assign bank_req.kind  = mapper_kind;
  assign bank_req.count = bank_count;
  assign bank_req.addr  = bus_address;
  assign bank_req.data  = data_byte;

  crbm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_addr[RAM_AW-1:0]),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (rd_addr[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  crbm_bank u_bank (
    .clk     (clk),
    .rst     (rst),
    .req     (bank_req),
    .rd_slot (rd_slot),
    .rd_bank (rd_bank),
    .done    (bank_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_kind  <= KIND_PLAIN;
      bank_count   <= 6'd1;
      base_segment <= 4'd0;
      rom_enabled  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_KIND:   mapper_kind  <= pwdata[2:0];
        REG_COUNT:  bank_count   <= pwdata[5:0];
        REG_BASE:   base_segment <= pwdata[3:0];
        REG_ENABLE: rom_enabled  <= pwdata[0];
        default:    rom_enabled  <= rom_enabled;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_READ)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            mode          <= s_tuser;
            bus_address   <= s_tdata[15:0];
            image_address <= s_tdata[33:16];
            data_byte     <= s_tdata[41:34];
            state         <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (ram_re) begin
            hold_addr <= rd_addr;
            state     <= ST_READ;
          end else if (bank_req.start) begin
            state <= ST_BANK;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (!m_tvalid || m_tready) begin
            read_data      <= ram_rdata;
            mapped_address <= hold_addr;
            m_tvalid       <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        ST_BANK: begin
          if (bank_done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
